// ===== hw/rtl/mpbm_pkg.sv =====
// shared types, codes and default sizes of the multi-pattern byte matcher
`timescale 1ns / 1ps
package mpbm_pkg;

	// default sizes
	localparam int NODES_DEF           = 1024;
	localparam int ALPHABET_DEF        = 256;
	localparam int PAT_SLOTS_DEF       = 16;
	localparam int MAX_PATTERN_LEN_DEF = 255;

	// reports held for one text byte
	localparam int MAX_RESULTS = 16;
	localparam int RCW         = 5;

	// item modes
	typedef enum logic [2:0] {
		MODE_CLEAR      = 3'd0,
		MODE_PAT_BYTE   = 3'd1,
		MODE_PAT_END    = 3'd2,
		MODE_BUILD      = 3'd3,
		MODE_TEXT       = 3'd4,
		MODE_TEXT_FIRST = 3'd5
	} mode_t;

	// answer status codes
	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_TABLE_FULL = 3'd1,
		STAT_PAT_FULL   = 3'd2,
		STAT_PAT_LONG   = 3'd3,
		STAT_NOT_BUILT  = 3'd4
	} status_t;

	// controller states
	typedef enum logic [4:0] {
		S_RST_SWEEP,
		S_IDLE,
		S_DISPATCH,
		S_SWEEP,
		S_PB_CHK,
		S_PE_WR,
		S_ANSWER,
		S_BR_RD,
		S_BR_CHK,
		S_B_POP,
		S_B_PAR,
		S_B_FPAR,
		S_B_RD,
		S_B_CHK,
		S_B_WRD,
		S_B_WCHK,
		S_B_WFAIL,
		S_GO_RD,
		S_GO_CHK,
		S_GO_FAIL,
		S_W_LOAD,
		S_W_SCAN,
		S_W_FAIL,
		S_EMIT
	} state_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_CLEAR,
		OP_SWEEP,
		OP_PB_RD,
		OP_PB_HIT,
		OP_PB_NEW,
		OP_PE_RD,
		OP_PE_WR,
		OP_PE_DROP,
		OP_ANSWER,
		OP_B_START,
		OP_BR_RD,
		OP_BR_CHK,
		OP_B_POP,
		OP_B_PAR,
		OP_B_FPAR,
		OP_B_RD,
		OP_B_CHK,
		OP_B_WRD,
		OP_B_WCHK,
		OP_B_WFAIL,
		OP_S_START,
		OP_GO_RD,
		OP_GO_CHK,
		OP_GO_FAIL,
		OP_W_LOAD,
		OP_W_SCAN,
		OP_W_FAIL,
		OP_EMIT
	} op_t;

	// command from controller to datapath
	typedef struct packed {
		op_t     op;
		logic    set_status;
		status_t status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  built;
		logic  pats_full;
		logic  len_full;
		logic  child_zero;
		logic  nodes_full;
		logic  node_root;
		logic  row_last;
		logic  queue_empty;
		logic  f_root;
		logic  rem_zero;
		logic  cnt_full;
		logic  cnt_zero;
		logic  t_root;
		logic  emit_last;
		logic  out_free;
	} stat_t;

endpackage

// ===== hw/rtl/multi_pattern_byte_matcher_top.sv =====
// top level of the multi-pattern byte matcher
`timescale 1ns / 1ps
// Aho-Corasick matcher: load patterns byte by byte, end each one, build the failure links,
// then stream text bytes; every item gets one status beat but a text byte after a build, which
// gets one match beat per pattern ending there (deepest node first, id ascending, at most 16,
// last one flagged) or none. All tables sit in single-port-write, registered-read memories,
// so time is set by memory read turnarounds: a text byte pays for each failure link followed
// to find the next state, each node on the output chain, each match and each emitted beat. A
// pattern byte that opens a new node clears its child row one entry a cycle; a build visits
// every root symbol, then every queued node, every symbol of each node and every child, with
// failure steps on top. After reset and after a clear item the root row is swept while no
// item is taken. Input is taken one item at a time; a finished beat may wait in the output
// register while the next item is taken.
module multi_pattern_byte_matcher_top #(
	parameter int NODES           = mpbm_pkg::NODES_DEF,
	parameter int ALPHABET        = mpbm_pkg::ALPHABET_DEF,
	parameter int PAT_SLOTS       = mpbm_pkg::PAT_SLOTS_DEF,
	parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  symbol,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [2:0]  status,
	output logic [31:0] position,
	output logic [3:0]  match_id,
	output logic [7:0]  match_len,
	output logic        last
);

	mpbm_pkg::cmd_t  cmd;
	mpbm_pkg::stat_t stat;

	// sequencer
	mpbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables and result register
	mpbm_dp #(
		.NODES           (NODES),
		.ALPHABET        (ALPHABET),
		.PAT_SLOTS       (PAT_SLOTS),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.status    (status),
		.position  (position),
		.match_id  (match_id),
		.match_len (match_len),
		.last      (last)
	);

endmodule

// ===== hw/rtl/mpbm_ctrl.sv =====
// controller state machine of the multi-pattern byte matcher
`timescale 1ns / 1ps
module mpbm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mpbm_pkg::stat_t stat,
	output mpbm_pkg::cmd_t  cmd
);

	mpbm_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpbm_pkg::S_RST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd.op         = mpbm_pkg::OP_NONE;
		cmd.set_status = 1'b0;
		cmd.status     = mpbm_pkg::STAT_OK;
		in_ready       = 1'b0;
		case (state_q)
			mpbm_pkg::S_RST_SWEEP: begin
				cmd.op = mpbm_pkg::OP_SWEEP;
				if (stat.row_last) state_d = mpbm_pkg::S_IDLE;
			end
			mpbm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = mpbm_pkg::OP_ACCEPT;
					state_d = mpbm_pkg::S_DISPATCH;
				end
			end
			mpbm_pkg::S_DISPATCH: begin
				cmd.set_status = 1'b1;
				state_d        = mpbm_pkg::S_ANSWER;
				case (stat.mode)
					mpbm_pkg::MODE_CLEAR: begin
						cmd.op  = mpbm_pkg::OP_CLEAR;
						state_d = mpbm_pkg::S_SWEEP;
					end
					mpbm_pkg::MODE_PAT_BYTE: begin
						if (stat.pats_full) begin
							cmd.status = mpbm_pkg::STAT_PAT_FULL;
						end else if (stat.len_full) begin
							cmd.status = mpbm_pkg::STAT_PAT_LONG;
						end else begin
							cmd.op  = mpbm_pkg::OP_PB_RD;
							state_d = mpbm_pkg::S_PB_CHK;
						end
					end
					mpbm_pkg::MODE_PAT_END: begin
						if (stat.pats_full) begin
							cmd.op     = mpbm_pkg::OP_PE_DROP;
							cmd.status = mpbm_pkg::STAT_PAT_FULL;
						end else begin
							cmd.op  = mpbm_pkg::OP_PE_RD;
							state_d = mpbm_pkg::S_PE_WR;
						end
					end
					mpbm_pkg::MODE_BUILD: begin
						cmd.op  = mpbm_pkg::OP_B_START;
						state_d = mpbm_pkg::S_BR_RD;
					end
					mpbm_pkg::MODE_TEXT, mpbm_pkg::MODE_TEXT_FIRST: begin
						if (!stat.built) begin
							cmd.status = mpbm_pkg::STAT_NOT_BUILT;
						end else begin
							cmd.op  = mpbm_pkg::OP_S_START;
							state_d = mpbm_pkg::S_GO_RD;
						end
					end
					default: begin
						cmd.status = mpbm_pkg::STAT_OK;
					end
				endcase
			end
			mpbm_pkg::S_SWEEP: begin
				cmd.op = mpbm_pkg::OP_SWEEP;
				if (stat.row_last) state_d = mpbm_pkg::S_ANSWER;
			end
			mpbm_pkg::S_PB_CHK: begin
				cmd.set_status = 1'b1;
				if (!stat.child_zero) begin
					cmd.op  = mpbm_pkg::OP_PB_HIT;
					state_d = mpbm_pkg::S_ANSWER;
				end else if (stat.nodes_full) begin
					cmd.status = mpbm_pkg::STAT_TABLE_FULL;
					state_d    = mpbm_pkg::S_ANSWER;
				end else begin
					cmd.op  = mpbm_pkg::OP_PB_NEW;
					state_d = mpbm_pkg::S_SWEEP;
				end
			end
			mpbm_pkg::S_PE_WR: begin
				cmd.op  = mpbm_pkg::OP_PE_WR;
				state_d = mpbm_pkg::S_ANSWER;
			end
			mpbm_pkg::S_ANSWER: begin
				cmd.op = mpbm_pkg::OP_ANSWER;
				if (stat.out_free) state_d = mpbm_pkg::S_IDLE;
			end
			// root children
			mpbm_pkg::S_BR_RD: begin
				cmd.op  = mpbm_pkg::OP_BR_RD;
				state_d = mpbm_pkg::S_BR_CHK;
			end
			mpbm_pkg::S_BR_CHK: begin
				cmd.op  = mpbm_pkg::OP_BR_CHK;
				state_d = stat.row_last ? mpbm_pkg::S_B_POP : mpbm_pkg::S_BR_RD;
			end
			// breadth-first walk over queued nodes
			mpbm_pkg::S_B_POP: begin
				cmd.op  = mpbm_pkg::OP_B_POP;
				state_d = stat.queue_empty ? mpbm_pkg::S_ANSWER : mpbm_pkg::S_B_PAR;
			end
			mpbm_pkg::S_B_PAR: begin
				cmd.op  = mpbm_pkg::OP_B_PAR;
				state_d = mpbm_pkg::S_B_FPAR;
			end
			mpbm_pkg::S_B_FPAR: begin
				cmd.op  = mpbm_pkg::OP_B_FPAR;
				state_d = mpbm_pkg::S_B_RD;
			end
			mpbm_pkg::S_B_RD: begin
				cmd.op  = mpbm_pkg::OP_B_RD;
				state_d = mpbm_pkg::S_B_CHK;
			end
			mpbm_pkg::S_B_CHK: begin
				cmd.op = mpbm_pkg::OP_B_CHK;
				if (stat.child_zero) begin
					state_d = stat.row_last ? mpbm_pkg::S_B_POP : mpbm_pkg::S_B_RD;
				end else begin
					state_d = mpbm_pkg::S_B_WRD;
				end
			end
			mpbm_pkg::S_B_WRD: begin
				cmd.op  = mpbm_pkg::OP_B_WRD;
				state_d = mpbm_pkg::S_B_WCHK;
			end
			mpbm_pkg::S_B_WCHK: begin
				cmd.op = mpbm_pkg::OP_B_WCHK;
				if (!stat.child_zero || stat.f_root) begin
					state_d = stat.row_last ? mpbm_pkg::S_B_POP : mpbm_pkg::S_B_RD;
				end else begin
					state_d = mpbm_pkg::S_B_WFAIL;
				end
			end
			mpbm_pkg::S_B_WFAIL: begin
				cmd.op  = mpbm_pkg::OP_B_WFAIL;
				state_d = mpbm_pkg::S_B_WRD;
			end
			// automaton move for a text byte
			mpbm_pkg::S_GO_RD: begin
				cmd.op  = mpbm_pkg::OP_GO_RD;
				state_d = mpbm_pkg::S_GO_CHK;
			end
			mpbm_pkg::S_GO_CHK: begin
				cmd.op = mpbm_pkg::OP_GO_CHK;
				if (!stat.node_root && stat.child_zero) begin
					state_d = mpbm_pkg::S_GO_FAIL;
				end else begin
					state_d = mpbm_pkg::S_W_LOAD;
				end
			end
			mpbm_pkg::S_GO_FAIL: begin
				cmd.op  = mpbm_pkg::OP_GO_FAIL;
				state_d = mpbm_pkg::S_GO_RD;
			end
			// output chain walk
			mpbm_pkg::S_W_LOAD: begin
				cmd.op  = mpbm_pkg::OP_W_LOAD;
				state_d = mpbm_pkg::S_W_SCAN;
			end
			mpbm_pkg::S_W_SCAN: begin
				cmd.op = mpbm_pkg::OP_W_SCAN;
				if (!stat.rem_zero && !stat.cnt_full) begin
					state_d = mpbm_pkg::S_W_SCAN;
				end else if (!stat.t_root && !stat.cnt_full) begin
					state_d = mpbm_pkg::S_W_FAIL;
				end else begin
					state_d = stat.cnt_zero ? mpbm_pkg::S_IDLE : mpbm_pkg::S_EMIT;
				end
			end
			mpbm_pkg::S_W_FAIL: begin
				cmd.op  = mpbm_pkg::OP_W_FAIL;
				state_d = mpbm_pkg::S_W_LOAD;
			end
			mpbm_pkg::S_EMIT: begin
				cmd.op = mpbm_pkg::OP_EMIT;
				if (stat.out_free && stat.emit_last) state_d = mpbm_pkg::S_IDLE;
			end
			default: begin
				state_d = mpbm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mpbm_dp.sv =====
// datapath of the multi-pattern byte matcher: tables, counters and result register
`timescale 1ns / 1ps
module mpbm_dp #(
	parameter int NODES           = mpbm_pkg::NODES_DEF,
	parameter int ALPHABET        = mpbm_pkg::ALPHABET_DEF,
	parameter int PAT_SLOTS       = mpbm_pkg::PAT_SLOTS_DEF,
	parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mpbm_pkg::cmd_t  cmd,
	output mpbm_pkg::stat_t stat,
	input  logic [2:0]      mode,
	input  logic [7:0]      symbol,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            kind,
	output logic [2:0]      status,
	output logic [31:0]     position,
	output logic [3:0]      match_id,
	output logic [7:0]      match_len,
	output logic            last
);

	localparam int NW  = $clog2(NODES);
	localparam int SW  = $clog2(ALPHABET);
	localparam int AW  = NW + SW;
	localparam int MW  = PAT_SLOTS;
	localparam int IDW = (PAT_SLOTS > 1) ? $clog2(PAT_SLOTS) : 1;
	localparam int PCW = $clog2(PAT_SLOTS + 1);
	localparam int RCW = mpbm_pkg::RCW;
	localparam int RIW = $clog2(mpbm_pkg::MAX_RESULTS);

	// memories
	logic [NW-1:0] child_mem [2**AW];
	logic [NW-1:0] fail_mem  [NODES];
	logic [MW-1:0] mask_mem  [NODES];
	logic [NW-1:0] queue_mem [NODES];

	logic [NW-1:0] child_rd_q, fail_rd_q, queue_rd_q;
	logic [MW-1:0] mask_rd_q;

	logic          child_we, fail_we, mask_we, queue_we;
	logic [AW-1:0] child_wa, child_ra;
	logic [NW-1:0] child_wd;
	logic [NW-1:0] fail_wa, fail_ra, fail_wd;
	logic [NW-1:0] mask_wa, mask_ra;
	logic [MW-1:0] mask_wd;
	logic [NW-1:0] queue_wa, queue_ra;

	// control registers
	mpbm_pkg::mode_t   mode_q;
	mpbm_pkg::status_t status_q;
	logic [SW-1:0]  sym_q, sym_red;
	logic [NW:0]    nodes_used_q;
	logic [PCW-1:0] pats_q;
	logic [NW-1:0]  ins_q;
	logic [7:0]     ins_len_q;
	logic [NW-1:0]  cur_q;
	logic [31:0]    pos_q;
	logic           built_q;
	logic [NW-1:0]  sweep_node_q;
	logic [SW-1:0]  row_q;
	logic [NW:0]    head_q, tail_q;
	logic [NW-1:0]  par_q, fpar_q, c_q, f_q, node_q, t_q;
	logic [MW-1:0]  rem_q;
	logic [RCW-1:0] cnt_q, emit_q;

	// payload registers
	logic [7:0]     lens_q    [PAT_SLOTS];
	logic [IDW-1:0] res_id_q  [mpbm_pkg::MAX_RESULTS];
	logic [7:0]     res_len_q [mpbm_pkg::MAX_RESULTS];

	// output register
	logic        out_valid_q, kind_q, last_q;
	logic [2:0]  ostat_q;
	logic [31:0] opos_q;
	logic [3:0]  oid_q;
	logic [7:0]  olen_q;

	logic           child_zero, tail_ok, take, out_free, emit_last;
	logic [IDW-1:0] ffs;
	logic [MW-1:0]  pat_bit;
	logic [32:0]    end_pos, start_pos;
	logic [RIW-1:0] emit_idx;
	logic [IDW+3:0] id_ext;

	// symbol reduced modulo the alphabet size
	always_comb begin
		sym_red = '0;
		for (int i = 0; i < 256; i++) begin
			if (symbol == 8'(i)) sym_red = SW'(i % ALPHABET);
		end
	end

	// lowest pending pattern bit at the current node
	always_comb begin
		ffs = '0;
		for (int i = MW - 1; i >= 0; i--) begin
			if (rem_q[i]) ffs = IDW'(i);
		end
	end

	assign child_zero = (child_rd_q == '0);
	assign tail_ok    = (tail_q < (NW + 1)'(NODES));
	assign take       = (rem_q != '0) && (cnt_q != RCW'(mpbm_pkg::MAX_RESULTS));
	assign out_free   = !out_valid_q || out_ready;
	assign pat_bit    = MW'(1) << pats_q[IDW-1:0];
	assign emit_idx   = emit_q[RIW-1:0];
	assign emit_last  = (emit_q == (cnt_q - RCW'(1)));

	// start offset of a report, saturated
	assign end_pos   = {1'b0, pos_q} + 33'd1;
	assign start_pos = (end_pos >= {25'd0, res_len_q[emit_idx]}) ?
		end_pos - {25'd0, res_len_q[emit_idx]} : 33'd0;
	assign id_ext    = {4'd0, res_id_q[emit_idx]};

	// status toward the controller
	always_comb begin
		stat.mode        = mode_q;
		stat.built       = built_q;
		stat.pats_full   = (pats_q >= PCW'(PAT_SLOTS));
		stat.len_full    = (ins_len_q >= 8'(MAX_PATTERN_LEN));
		stat.child_zero  = child_zero;
		stat.nodes_full  = (nodes_used_q >= (NW + 1)'(NODES));
		stat.node_root   = (node_q == '0);
		stat.row_last    = (row_q == SW'(ALPHABET - 1));
		stat.queue_empty = (head_q == tail_q);
		stat.f_root      = (f_q == '0);
		stat.rem_zero    = (rem_q == '0);
		stat.cnt_full    = (cnt_q == RCW'(mpbm_pkg::MAX_RESULTS));
		stat.cnt_zero    = (cnt_q == '0);
		stat.t_root      = (t_q == '0);
		stat.emit_last   = emit_last;
		stat.out_free    = out_free;
	end

	// memory port addresses and writes
	always_comb begin
		child_we = 1'b0;
		child_wa = '0;
		child_wd = '0;
		child_ra = '0;
		fail_we  = 1'b0;
		fail_wa  = '0;
		fail_wd  = '0;
		fail_ra  = '0;
		mask_we  = 1'b0;
		mask_wa  = '0;
		mask_wd  = '0;
		mask_ra  = '0;
		queue_we = 1'b0;
		queue_wa = tail_q[NW-1:0];
		queue_ra = head_q[NW-1:0];
		case (cmd.op)
			mpbm_pkg::OP_SWEEP: begin
				child_we = 1'b1;
				child_wa = {sweep_node_q, row_q};
				mask_we  = 1'b1;
				mask_wa  = sweep_node_q;
			end
			mpbm_pkg::OP_PB_RD: child_ra = {ins_q, sym_q};
			mpbm_pkg::OP_PB_NEW: begin
				child_we = 1'b1;
				child_wa = {ins_q, sym_q};
				child_wd = nodes_used_q[NW-1:0];
			end
			mpbm_pkg::OP_PE_RD: mask_ra = ins_q;
			mpbm_pkg::OP_PE_WR: begin
				mask_we = 1'b1;
				mask_wa = ins_q;
				mask_wd = mask_rd_q | pat_bit;
			end
			mpbm_pkg::OP_BR_RD: child_ra = {NW'(0), row_q};
			mpbm_pkg::OP_BR_CHK: begin
				if (!child_zero && tail_ok) begin
					fail_we  = 1'b1;
					fail_wa  = child_rd_q;
					queue_we = 1'b1;
				end
			end
			mpbm_pkg::OP_B_PAR: fail_ra = queue_rd_q;
			mpbm_pkg::OP_B_RD: child_ra = {par_q, row_q};
			mpbm_pkg::OP_B_CHK: begin
				if (!child_zero && tail_ok) queue_we = 1'b1;
			end
			mpbm_pkg::OP_B_WRD: child_ra = {f_q, row_q};
			mpbm_pkg::OP_B_WCHK: begin
				if (!child_zero || f_q == '0) begin
					fail_we = 1'b1;
					fail_wa = c_q;
					fail_wd = child_rd_q;
				end else begin
					fail_ra = f_q;
				end
			end
			mpbm_pkg::OP_GO_RD: child_ra = {node_q, sym_q};
			mpbm_pkg::OP_GO_CHK: begin
				if (node_q != '0 && child_zero) begin
					fail_ra = node_q;
				end else begin
					mask_ra = child_rd_q;
				end
			end
			mpbm_pkg::OP_W_SCAN: fail_ra = t_q;
			mpbm_pkg::OP_W_FAIL: mask_ra = fail_rd_q;
			default: begin
				child_we = 1'b0;
			end
		endcase
	end

	// child transition table
	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		child_rd_q <= child_mem[child_ra];
	end

	// failure links
	always_ff @(posedge clk) begin
		if (fail_we) fail_mem[fail_wa] <= fail_wd;
		fail_rd_q <= fail_mem[fail_ra];
	end

	// per-node pattern masks
	always_ff @(posedge clk) begin
		if (mask_we) mask_mem[mask_wa] <= mask_wd;
		mask_rd_q <= mask_mem[mask_ra];
	end

	// breadth-first queue
	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[queue_wa] <= child_rd_q;
		queue_rd_q <= queue_mem[queue_ra];
	end

	// pattern lengths and collected reports
	always_ff @(posedge clk) begin
		if (cmd.op == mpbm_pkg::OP_PE_WR) lens_q[pats_q[IDW-1:0]] <= ins_len_q;
		if (cmd.op == mpbm_pkg::OP_W_SCAN && take) begin
			res_id_q[cnt_q[RIW-1:0]]  <= ffs;
			res_len_q[cnt_q[RIW-1:0]] <= lens_q[ffs];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= mpbm_pkg::MODE_CLEAR;
			status_q     <= mpbm_pkg::STAT_OK;
			sym_q        <= '0;
			nodes_used_q <= (NW + 1)'(1);
			pats_q       <= '0;
			ins_q        <= '0;
			ins_len_q    <= '0;
			cur_q        <= '0;
			pos_q        <= '0;
			built_q      <= 1'b0;
			sweep_node_q <= '0;
			row_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			par_q        <= '0;
			fpar_q       <= '0;
			c_q          <= '0;
			f_q          <= '0;
			node_q       <= '0;
			t_q          <= '0;
			rem_q        <= '0;
			cnt_q        <= '0;
			emit_q       <= '0;
		end else begin
			if (cmd.set_status) status_q <= cmd.status;
			case (cmd.op)
				mpbm_pkg::OP_ACCEPT: begin
					mode_q <= mpbm_pkg::mode_t'(mode);
					sym_q  <= sym_red;
				end
				mpbm_pkg::OP_CLEAR: begin
					nodes_used_q <= (NW + 1)'(1);
					pats_q       <= '0;
					ins_q        <= '0;
					ins_len_q    <= '0;
					cur_q        <= '0;
					pos_q        <= '0;
					built_q      <= 1'b0;
					sweep_node_q <= '0;
					row_q        <= '0;
				end
				mpbm_pkg::OP_SWEEP: row_q <= row_q + SW'(1);
				mpbm_pkg::OP_PB_HIT: begin
					ins_q     <= child_rd_q;
					ins_len_q <= ins_len_q + 8'd1;
					built_q   <= 1'b0;
				end
				mpbm_pkg::OP_PB_NEW: begin
					ins_q        <= nodes_used_q[NW-1:0];
					sweep_node_q <= nodes_used_q[NW-1:0];
					nodes_used_q <= nodes_used_q + (NW + 1)'(1);
					ins_len_q    <= ins_len_q + 8'd1;
					row_q        <= '0;
					built_q      <= 1'b0;
				end
				mpbm_pkg::OP_PE_WR: begin
					pats_q    <= pats_q + PCW'(1);
					ins_q     <= '0;
					ins_len_q <= '0;
					built_q   <= 1'b0;
				end
				mpbm_pkg::OP_PE_DROP: begin
					ins_q     <= '0;
					ins_len_q <= '0;
				end
				mpbm_pkg::OP_B_START: begin
					head_q <= '0;
					tail_q <= '0;
					row_q  <= '0;
				end
				mpbm_pkg::OP_BR_CHK: begin
					if (!child_zero && tail_ok) tail_q <= tail_q + (NW + 1)'(1);
					row_q <= row_q + SW'(1);
				end
				mpbm_pkg::OP_B_POP: begin
					if (head_q == tail_q) built_q <= 1'b1;
				end
				mpbm_pkg::OP_B_PAR: begin
					par_q  <= queue_rd_q;
					head_q <= head_q + (NW + 1)'(1);
				end
				mpbm_pkg::OP_B_FPAR: begin
					fpar_q <= fail_rd_q;
					row_q  <= '0;
				end
				mpbm_pkg::OP_B_CHK: begin
					if (child_zero) begin
						row_q <= row_q + SW'(1);
					end else begin
						c_q <= child_rd_q;
						f_q <= fpar_q;
						if (tail_ok) tail_q <= tail_q + (NW + 1)'(1);
					end
				end
				mpbm_pkg::OP_B_WCHK: begin
					if (!child_zero || f_q == '0) row_q <= row_q + SW'(1);
				end
				mpbm_pkg::OP_B_WFAIL: f_q <= fail_rd_q;
				mpbm_pkg::OP_S_START: begin
					cnt_q <= '0;
					if (mode_q == mpbm_pkg::MODE_TEXT_FIRST) begin
						cur_q  <= '0;
						pos_q  <= '0;
						node_q <= '0;
					end else begin
						node_q <= cur_q;
					end
				end
				mpbm_pkg::OP_GO_CHK: begin
					if (!(node_q != '0 && child_zero)) begin
						cur_q <= child_rd_q;
						t_q   <= child_rd_q;
					end
				end
				mpbm_pkg::OP_GO_FAIL: node_q <= fail_rd_q;
				mpbm_pkg::OP_W_LOAD: rem_q <= mask_rd_q;
				mpbm_pkg::OP_W_SCAN: begin
					if (take) begin
						cnt_q      <= cnt_q + RCW'(1);
						rem_q[ffs] <= 1'b0;
					end else if (!(t_q != '0 && cnt_q != RCW'(mpbm_pkg::MAX_RESULTS))) begin
						emit_q <= '0;
						if (cnt_q == '0 && pos_q != '1) pos_q <= pos_q + 32'd1;
					end
				end
				mpbm_pkg::OP_W_FAIL: t_q <= fail_rd_q;
				mpbm_pkg::OP_EMIT: begin
					if (out_free) begin
						emit_q <= emit_q + RCW'(1);
						if (emit_last && pos_q != '1) pos_q <= pos_q + 32'd1;
					end
				end
				default: begin
					row_q <= row_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == mpbm_pkg::OP_ANSWER || cmd.op == mpbm_pkg::OP_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.op == mpbm_pkg::OP_ANSWER && out_free) begin
			kind_q  <= 1'b0;
			ostat_q <= status_q;
			opos_q  <= '0;
			oid_q   <= '0;
			olen_q  <= '0;
			last_q  <= 1'b1;
		end else if (cmd.op == mpbm_pkg::OP_EMIT && out_free) begin
			kind_q  <= 1'b1;
			ostat_q <= mpbm_pkg::STAT_OK;
			opos_q  <= start_pos[32] ? 32'hFFFF_FFFF : start_pos[31:0];
			oid_q   <= id_ext[3:0];
			olen_q  <= res_len_q[emit_idx];
			last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = ostat_q;
	assign position  = opos_q;
	assign match_id  = oid_q;
	assign match_len = olen_q;
	assign last      = last_q;

endmodule

// ===== tb/testbench.sv =====
// testbench for the multi-pattern byte matcher: scoreboard with trie predictor, random phases
`timescale 1ns / 1ps
module testbench;

	localparam int TRIE_NODES   = 1024;
	localparam int SYMS         = 256;
	localparam int PAT_SLOTS    = 16;
	localparam int PAT_MAX_LEN  = 255;
	localparam int REPORT_CAP   = 16;
	localparam int STALL_LIMIT  = 400000;
	localparam int SQUEEZE_LEN  = 400;
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	// one output beat
	typedef struct {
		logic        kind;
		logic [2:0]  status;
		logic [31:0] position;
		logic [3:0]  match_id;
		logic [7:0]  match_len;
		logic        last;
	} beat_t;

	// predictor of the matcher and queue of beats it still owes
	class match_board;
		beat_t          owed[$];
		int             errors;
		logic [9:0]     kids[int];
		logic [9:0]     fail_link[TRIE_NODES];
		logic [15:0]    ends_here[TRIE_NODES];
		logic [7:0]     pat_len[PAT_SLOTS];
		int             nodes_used, pats_loaded, ins_node, ins_len, cur_node;
		logic [31:0]    text_pos;
		bit             built;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			kids.delete();
			foreach (fail_link[i]) fail_link[i] = '0;
			foreach (ends_here[i]) ends_here[i] = '0;
			foreach (pat_len[i]) pat_len[i] = '0;
			nodes_used = 1;
			pats_loaded = 0;
			ins_node = 0;
			ins_len = 0;
			cur_node = 0;
			text_pos = '0;
			built = 0;
		endfunction

		function int child(int node, int sym);
			int key;
			key = node * SYMS + sym;
			return kids.exists(key) ? int'(kids[key]) : 0;
		endfunction

		function void owe_status(mpbm_pkg::status_t st);
			beat_t b;
			b.kind = 1'b0;
			b.status = st;
			b.position = '0;
			b.match_id = '0;
			b.match_len = '0;
			b.last = 1'b1;
			owed.push_back(b);
		endfunction

		// breadth-first failure link construction
		function void link_trie();
			int bfs[$];
			int par, c, f, g, lnk;
			fail_link[0] = '0;
			for (int s = 0; s < SYMS; s++) begin
				c = child(0, s);
				if (c != 0) begin
					fail_link[c] = '0;
					bfs.push_back(c);
				end
			end
			while (bfs.size() > 0) begin
				par = bfs.pop_front();
				for (int s = 0; s < SYMS; s++) begin
					c = child(par, s);
					if (c == 0) continue;
					bfs.push_back(c);
					f = fail_link[par];
					lnk = 0;
					forever begin
						g = child(f, s);
						if (g != 0) begin
							lnk = g;
							break;
						end
						if (f == 0) break;
						f = fail_link[f];
					end
					fail_link[c] = lnk[9:0];
				end
			end
			built = 1;
		endfunction

		// one text byte: advance the automaton and report the output chain
		function void scan(int sym);
			int node, t, count, first;
			longint unsigned fin, start;
			node = cur_node;
			while (node != 0 && child(node, sym) == 0)
				node = fail_link[node];
			cur_node = child(node, sym);
			first = owed.size();
			count = 0;
			t = cur_node;
			forever begin
				for (int id = 0; id < PAT_SLOTS; id++) begin
					if (ends_here[t][id] && count < REPORT_CAP) begin
						beat_t b;
						fin = longint'(text_pos) + 1;
						start = (fin >= pat_len[id]) ? fin - pat_len[id] : 0;
						b.kind = 1'b1;
						b.status = mpbm_pkg::STAT_OK;
						// start offset saturates at the top of the 32-bit range
						b.position = (start > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : start[31:0];
						b.match_id = id[3:0];
						b.match_len = pat_len[id];
						b.last = 1'b0;
						owed.push_back(b);
						count++;
					end
				end
				if (t == 0) break;
				t = fail_link[t];
			end
			if (text_pos != 32'hFFFF_FFFF) text_pos++;
			if (count > 0) owed[first + count - 1].last = 1'b1;
		endfunction

		// an input beat was taken
		function void note_item(logic [2:0] m, logic [7:0] sym);
			int c, key;
			case (m)
				mpbm_pkg::MODE_CLEAR: begin
					wipe();
					owe_status(mpbm_pkg::STAT_OK);
				end
				mpbm_pkg::MODE_PAT_BYTE: begin
					if (pats_loaded >= PAT_SLOTS) owe_status(mpbm_pkg::STAT_PAT_FULL);
					else if (ins_len >= PAT_MAX_LEN) owe_status(mpbm_pkg::STAT_PAT_LONG);
					else begin
						key = ins_node * SYMS + sym;
						c = child(ins_node, sym);
						if (c == 0 && nodes_used >= TRIE_NODES)
							owe_status(mpbm_pkg::STAT_TABLE_FULL);
						else begin
							if (c == 0) begin
								c = nodes_used++;
								kids[key] = c[9:0];
							end
							ins_node = c;
							ins_len++;
							built = 0;
							owe_status(mpbm_pkg::STAT_OK);
						end
					end
				end
				mpbm_pkg::MODE_PAT_END: begin
					if (pats_loaded >= PAT_SLOTS) owe_status(mpbm_pkg::STAT_PAT_FULL);
					else begin
						ends_here[ins_node][pats_loaded] = 1'b1;
						pat_len[pats_loaded] = ins_len[7:0];
						pats_loaded++;
						built = 0;
						owe_status(mpbm_pkg::STAT_OK);
					end
					ins_node = 0;
					ins_len = 0;
				end
				mpbm_pkg::MODE_BUILD: begin
					link_trie();
					owe_status(mpbm_pkg::STAT_OK);
				end
				mpbm_pkg::MODE_TEXT, mpbm_pkg::MODE_TEXT_FIRST: begin
					if (!built) owe_status(mpbm_pkg::STAT_NOT_BUILT);
					else begin
						if (m == mpbm_pkg::MODE_TEXT_FIRST) begin
							cur_node = 0;
							text_pos = '0;
						end
						scan(sym);
					end
				end
				default: owe_status(mpbm_pkg::STAT_OK);
			endcase
		endfunction

		// an output beat was taken
		function void check_beat(beat_t got);
			beat_t exp_b;
			if (owed.size() == 0) begin
				errors++;
				$error("unexpected beat kind=%0d status=%0d", got.kind, got.status);
				return;
			end
			exp_b = owed.pop_front();
			if (got.kind !== exp_b.kind) begin
				errors++;
				$error("kind: expected %0d, got %0d", exp_b.kind, got.kind);
			end
			if (got.status !== exp_b.status) begin
				errors++;
				$error("status: expected %0d, got %0d", exp_b.status, got.status);
			end
			if (got.position !== exp_b.position) begin
				errors++;
				$error("position: expected %0d, got %0d", exp_b.position, got.position);
			end
			if (got.match_id !== exp_b.match_id) begin
				errors++;
				$error("match_id: expected %0d, got %0d", exp_b.match_id, got.match_id);
			end
			if (got.match_len !== exp_b.match_len) begin
				errors++;
				$error("match_len: expected %0d, got %0d", exp_b.match_len, got.match_len);
			end
			if (got.last !== exp_b.last) begin
				errors++;
				$error("last: expected %0d, got %0d", exp_b.last, got.last);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [2:0]  mode;
	logic [7:0]  symbol;
	logic        kind, last;
	logic [2:0]  status;
	logic [31:0] position;
	logic [3:0]  match_id;
	logic [7:0]  match_len;

	match_board board;
	int  idle_pct;
	bit  calm;
	bit  squeeze;
	int  quiet_cycles;

	multi_pattern_byte_matcher_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .symbol(symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .status(status), .position(position), .match_id(match_id),
		.match_len(match_len), .last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: check beats, stall in bursts, one long hold-off on request
	initial begin
		int stall;
		beat_t got;
		stall = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind = kind;
				got.status = status;
				got.position = position;
				got.match_id = match_id;
				got.match_len = match_len;
				got.last = last;
				board.check_beat(got);
			end
			if (squeeze) begin
				squeeze = 0;
				stall = SQUEEZE_LEN;
			end else if (stall == 0 && !calm && $urandom_range(0, 99) < idle_pct)
				stall = $urandom_range(1, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else
				out_ready <= 1'b1;
		end
	end

	// offer one beat, with an optional gap first
	task automatic send_item(logic [2:0] m, logic [7:0] sym);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		symbol <= sym;
		do @(posedge clk); while (!in_ready);
		board.note_item(m, sym);
	endtask

	task automatic send_pattern(logic [7:0] bytes[$]);
		foreach (bytes[i]) send_item(mpbm_pkg::MODE_PAT_BYTE, bytes[i]);
		send_item(mpbm_pkg::MODE_PAT_END, 8'h00);
	endtask

	// one random session: clear, load patterns over a small byte set, usually link, scan text
	task automatic random_session(int budget, bit press);
		logic [7:0] set[$];
		logic [7:0] pat[$];
		int npat, plen, sent;
		sent = 0;
		idle_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
		send_item(mpbm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(2, 5)) set.push_back(8'($urandom_range(0, 255)));
		npat = $urandom_range(0, 5) == 0 ? $urandom_range(15, 18) : $urandom_range(1, 8);
		for (int p = 0; p < npat; p++) begin
			pat.delete();
			plen = $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 5);
			repeat (plen) pat.push_back(set[$urandom_range(0, set.size() - 1)]);
			send_pattern(pat);
			sent += plen + 1;
			if ($urandom_range(0, 9) == 0) begin
				send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				sent++;
			end
		end
		if ($urandom_range(0, 7) != 0)
			send_item(mpbm_pkg::MODE_BUILD, 8'($urandom_range(0, 255)));
		if (press) squeeze = 1;
		send_item(mpbm_pkg::MODE_TEXT_FIRST, set[$urandom_range(0, set.size() - 1)]);
		sent += 2;
		while (sent < budget) begin
			if ($urandom_range(0, 19) == 0)
				send_item(mpbm_pkg::MODE_TEXT_FIRST, 8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 9) == 0)
				send_item(mpbm_pkg::MODE_TEXT, 8'($urandom_range(0, 255)));
			else
				send_item(mpbm_pkg::MODE_TEXT, set[$urandom_range(0, set.size() - 1)]);
			sent++;
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] pat[$];
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = mpbm_pkg::MODE_CLEAR;
		symbol = '0;
		idle_pct = 10;
		calm = 0;
		squeeze = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unbuilt text, spare modes, extreme bytes, empty pattern, 16 same-end hits
		send_item(mpbm_pkg::MODE_TEXT_FIRST, 8'hFF);
		send_item(MODE_SPARE_A, 8'h00);
		send_item(MODE_SPARE_B, 8'hFF);
		pat = '{8'h00, 8'hFF};
		send_pattern(pat);
		pat.delete();
		send_pattern(pat);
		pat = '{8'hFF};
		send_pattern(pat);
		send_item(mpbm_pkg::MODE_TEXT, 8'h00);
		send_item(mpbm_pkg::MODE_BUILD, 8'h00);
		send_item(mpbm_pkg::MODE_TEXT_FIRST, 8'h00);
		send_item(mpbm_pkg::MODE_TEXT, 8'hFF);
		send_item(mpbm_pkg::MODE_TEXT, 8'hFF);
		send_item(mpbm_pkg::MODE_CLEAR, 8'hFF);
		pat = '{8'h5A};
		repeat (15) send_pattern(pat);
		send_item(mpbm_pkg::MODE_PAT_BYTE, 8'h5A);
		send_item(mpbm_pkg::MODE_PAT_END, 8'h00);
		send_item(mpbm_pkg::MODE_BUILD, 8'h00);
		send_item(mpbm_pkg::MODE_TEXT_FIRST, 8'h5A);

		// random sessions, one with a long result hold-off
		for (int k = 0; k < 4; k++) random_session($urandom_range(30, 45), k == 2);

		// store limits: pattern slots
		idle_pct = 0;
		send_item(mpbm_pkg::MODE_CLEAR, 8'h00);
		pat = '{8'hA5};
		repeat (16) send_pattern(pat);
		send_item(mpbm_pkg::MODE_PAT_BYTE, 8'hA5);
		send_item(mpbm_pkg::MODE_PAT_END, 8'h00);

		// closing session without idling
		calm = 1;
		random_session(40, 0);
		in_valid <= 1'b0;

		while (board.owed.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
